/* rtl/core/ibs_pkg.sv */
`default_nettype none
package ibs_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam int CW = 36;

    typedef logic signed [CW-1:0] cw_t;

    typedef struct packed {
        cw_t x;
        cw_t y;
        cw_t z;
    } rot_t;

    localparam cw_t Q30_PI      = 36'sd3373259426;
    localparam cw_t Q30_HALF_PI = 36'sd1686629713;
    localparam cw_t Q30_TWO_PI  = 36'sd6746518852;
    localparam cw_t CORDIC_GAIN = 36'sd652032874;
    localparam cw_t Q30_ONE     = 36'sd1073741824;

    function automatic cw_t atan_entry(input logic [4:0] i);
        cw_t r;
        r = '0;
        case (i)
            5'd0:  r = 36'sd843314857;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043837;
            5'd3:  r = 36'sd133525159;
            5'd4:  r = 36'sd67021687;
            5'd5:  r = 36'sd33543516;
            5'd6:  r = 36'sd16775851;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194283;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048576;
            5'd31: r = '0;
            default: r = Q30_ONE >>> i;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/ibs_rot_cell.sv */
`default_nettype none
module ibs_rot_cell (
    input  wire logic          clk,
    input  wire logic [4:0]    step,
    input  wire ibs_pkg::rot_t din,
    output ibs_pkg::rot_t      dout
);
    ibs_pkg::rot_t nxt;
    ibs_pkg::rot_t out_reg;

    always_comb
    begin
        if (din.z >= 0)
        begin
            nxt.x = din.x - (din.y >>> step);
            nxt.y = din.y + (din.x >>> step);
            nxt.z = din.z - ibs_pkg::atan_entry(step);
        end
        else
        begin
            nxt.x = din.x + (din.y >>> step);
            nxt.y = din.y - (din.x >>> step);
            nxt.z = din.z + ibs_pkg::atan_entry(step);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= nxt;
    end

    assign dout = out_reg;
endmodule
`default_nettype wire

/* rtl/core/ibs_vec_cell.sv */
`default_nettype none
module ibs_vec_cell (
    input  wire logic          clk,
    input  wire logic [4:0]    step,
    input  wire ibs_pkg::rot_t din,
    output ibs_pkg::rot_t      dout
);
    ibs_pkg::rot_t nxt;
    ibs_pkg::rot_t out_reg;

    // drive y toward zero
    always_comb
    begin
        if (din.y > 0)
        begin
            nxt.x = din.x + (din.y >>> step);
            nxt.y = din.y - (din.x >>> step);
            nxt.z = din.z + ibs_pkg::atan_entry(step);
        end
        else
        begin
            nxt.x = din.x - (din.y >>> step);
            nxt.y = din.y + (din.x >>> step);
            nxt.z = din.z - ibs_pkg::atan_entry(step);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= nxt;
    end

    assign dout = out_reg;
endmodule
`default_nettype wire

/* rtl/core/initial_bearing_spherical_top.sv */
`default_nettype none
// Throughput: one point pair per cycle; busy stays low, the pipeline never stalls.
// Each step of the sine/cosine and atan2 CORDICs is one cell of a registered chain.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The receiver cannot stall: done pulses for one cycle with bearing.
module initial_bearing_spherical_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output wire logic               busy,
    input  wire logic signed [29:0] lat_a,
    input  wire logic signed [30:0] lon_a,
    input  wire logic signed [29:0] lat_b,
    input  wire logic signed [30:0] lon_b,
    output wire logic               done,
    output wire logic        [24:0] bearing
);
    localparam int S = ibs_pkg::CORDIC_STEPS;
    localparam logic signed [67:0] DEG_SCALE = 68'sd961263669;
    localparam logic signed [67:0] DEG_HALF  = 68'sd137438953472;
    localparam logic signed [30:0] FULL_TURN = 31'sd23592960;

    // lane 0: lat_a, lane 1: lat_b, lane 2: dlon
    ibs_pkg::rot_t lane [3][S+1];
    logic [5:0]    flg_reg [S+1];
    logic [S:0]    rv_reg;

    ibs_pkg::rot_t vch [S+1];
    logic [S:0]    vv_reg;
    logic [S:0]    zf_reg;

    ibs_pkg::cw_t  ang [3];
    ibs_pkg::cw_t  red [3];
    logic [2:0]    neg;
    logic [2:0]    zer;

    always_comb
    begin
        ang[0] = ibs_pkg::cw_t'(lat_a) <<< 2;
        ang[1] = ibs_pkg::cw_t'(lat_b) <<< 2;
        ang[2] = (ibs_pkg::cw_t'(lon_b) - ibs_pkg::cw_t'(lon_a)) <<< 2;
        for (int k = 0; k < 3; k++)
        begin
            red[k] = ang[k];
            if (red[k] > ibs_pkg::Q30_PI)
                red[k] = red[k] - ibs_pkg::Q30_TWO_PI;
            else if (red[k] < -ibs_pkg::Q30_PI)
                red[k] = red[k] + ibs_pkg::Q30_TWO_PI;
            neg[k] = 1'b0;
            if (red[k] > ibs_pkg::Q30_HALF_PI)
            begin
                red[k] = red[k] - ibs_pkg::Q30_PI;
                neg[k] = 1'b1;
            end
            else if (red[k] < -ibs_pkg::Q30_HALF_PI)
            begin
                red[k] = red[k] + ibs_pkg::Q30_PI;
                neg[k] = 1'b1;
            end
            zer[k] = (red[k] == 0);
        end
    end

    genvar gl, gs;
    generate
        for (gl = 0; gl < 3; gl++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                lane[gl][0].x <= ibs_pkg::CORDIC_GAIN;
                lane[gl][0].y <= '0;
                lane[gl][0].z <= red[gl];
            end
            for (gs = 0; gs < S; gs++)
            begin : g_rot
                ibs_rot_cell u_cell (
                    .clk  (clk),
                    .step (5'(gs)),
                    .din  (lane[gl][gs]),
                    .dout (lane[gl][gs+1])
                );
            end
        end
        for (gs = 0; gs < S; gs++)
        begin : g_vec
            ibs_vec_cell u_cell (
                .clk  (clk),
                .step (5'(gs)),
                .din  (vch[gs]),
                .dout (vch[gs+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        flg_reg[0] <= {zer, neg};
        for (int k = 1; k <= S; k++)
            flg_reg[k] <= flg_reg[k-1];
    end

    // sine and cosine after the rotation chain
    ibs_pkg::cw_t sn [3];
    ibs_pkg::cw_t cs [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (flg_reg[S][3+k])
            begin
                sn[k] = '0;
                cs[k] = flg_reg[S][k] ? -ibs_pkg::Q30_ONE : ibs_pkg::Q30_ONE;
            end
            else
            begin
                sn[k] = flg_reg[S][k] ? -lane[k][S].y : lane[k][S].y;
                cs[k] = flg_reg[S][k] ? -lane[k][S].x : lane[k][S].x;
            end
        end
    end

    logic signed [71:0] p1_reg, p2_reg, p3_reg, m_reg;
    ibs_pkg::cw_t       cd_reg, yb_reg, xs_reg;
    logic               va_reg, vb_reg;
    logic signed [35:0] t3;
    logic signed [71:0] p1s, p2s, p3s;

    assign p1s = p1_reg >>> 30;
    assign p2s = p2_reg >>> 30;
    assign p3s = p3_reg >>> 30;
    assign t3  = p3s[35:0];

    always_ff @(posedge clk)
    begin
        p1_reg  <= 72'(sn[2]) * 72'(cs[1]);
        p2_reg  <= 72'(cs[0]) * 72'(sn[1]);
        p3_reg  <= 72'(sn[0]) * 72'(cs[1]);
        cd_reg  <= cs[2];
        yb_reg  <= p1s[35:0];
        xs_reg  <= p2s[35:0];
        m_reg   <= 72'(t3) * 72'(cd_reg);
    end

    ibs_pkg::cw_t       xc, yc;
    logic signed [71:0] ms;
    assign ms = m_reg >>> 30;
    assign xc = xs_reg - ms[35:0];
    assign yc = yb_reg;

    always_ff @(posedge clk)
    begin
        zf_reg <= {zf_reg[S-1:0], (xc == 0) && (yc == 0)};
        if (xc < 0)
        begin
            vch[0].x <= -xc;
            vch[0].y <= -yc;
            vch[0].z <= (yc >= 0) ? ibs_pkg::Q30_PI : -ibs_pkg::Q30_PI;
        end
        else
        begin
            vch[0].x <= xc;
            vch[0].y <= yc;
            vch[0].z <= '0;
        end
    end

    logic signed [67:0] prod_reg;
    logic               zd_reg;
    logic signed [67:0] rnd;
    logic signed [30:0] deg0, deg1;
    logic [24:0]        bearing_reg;
    logic               vd_reg, done_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 68'(vch[S].z) * DEG_SCALE;
        zd_reg   <= zf_reg[S];
    end

    always_comb
    begin
        rnd  = prod_reg + DEG_HALF;
        deg0 = 31'(rnd >>> 38);
        deg1 = deg0;
        if (deg1 < 0)
            deg1 = deg1 + FULL_TURN;
        if (deg1 >= FULL_TURN)
            deg1 = deg1 - FULL_TURN;
        if (deg1 < 0)
            deg1 = '0;
        if (zd_reg)
            deg1 = '0;
    end

    always_ff @(posedge clk)
    begin
        bearing_reg <= deg1[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg   <= '0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vv_reg   <= '0;
            vd_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rv_reg   <= {rv_reg[S-1:0], start};
            va_reg   <= rv_reg[S];
            vb_reg   <= va_reg;
            vv_reg   <= {vv_reg[S-1:0], vb_reg};
            vd_reg   <= vv_reg[S];
            done_reg <= vd_reg;
        end
    end

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign bearing = bearing_reg;
endmodule
`default_nettype wire

/* tb/tb_initial_bearing_spherical_top.sv */
`timescale 1ns / 1ps
module tb_initial_bearing_spherical_top;

    localparam int LATENCY = 2 * ibs_pkg::CORDIC_STEPS + 5;
    localparam longint LAT_MAX = 421657428;
    localparam longint LON_MAX = 843314857;
    localparam longint DEG_SCALE = 961263669;
    localparam longint FULL_TURN = 23592960;
    localparam longint Q_PI = 64'sd3373259426;
    localparam longint Q_HALF_PI = 64'sd1686629713;
    localparam longint Q_TWO_PI = 64'sd6746518852;
    localparam longint Q_GAIN = 64'sd652032874;
    localparam longint CYCLE_LIMIT = 200000;
    localparam int N_DIR = 16;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [29:0] lat_a;
    logic signed [30:0] lon_a;
    logic signed [29:0] lat_b;
    logic signed [30:0] lon_b;
    logic done;
    logic [24:0] bearing;

    initial_bearing_spherical_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .done(done), .bearing(bearing)
    );

    typedef struct {
        logic signed [29:0] la;
        logic signed [30:0] oa;
        logic signed [29:0] lb;
        logic signed [30:0] ob;
        bit known;
        logic [24:0] want;
    } pair_row_t;

    logic [24:0] bearing_q[$];
    int errors;
    int n_sent;
    int n_checked;
    longint cycles;
    int idle_pct;
    pair_row_t dir_rows[N_DIR];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arc_entry(int i);
        longint tbl[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11)
            return tbl[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic void rotate_sc(input longint ang, output longint s,
            output longint c);
        bit flip;
        longint x, y, z, dx, dy;
        flip = 0;
        x = Q_GAIN;
        y = 0;
        while (ang > Q_PI)
            ang -= Q_TWO_PI;
        while (ang < -Q_PI)
            ang += Q_TWO_PI;
        if (ang > Q_HALF_PI)
        begin
            ang -= Q_PI;
            flip = 1;
        end
        else if (ang < -Q_HALF_PI)
        begin
            ang += Q_PI;
            flip = 1;
        end
        if (ang == 0)
        begin
            s = 0;
            c = flip ? -(longint'(1) << 30) : (longint'(1) << 30);
            return;
        end
        z = ang;
        for (int i = 0; i < ibs_pkg::CORDIC_STEPS && i < 32; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_entry(i);
            end
            else
            begin
                x += dx; y -= dy; z += arc_entry(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? Q_PI : -Q_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ibs_pkg::CORDIC_STEPS && i < 32; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += arc_entry(i);
            end
            else
            begin
                x -= dx; y += dy; z -= arc_entry(i);
            end
        end
        return z;
    endfunction

    function automatic logic [24:0] predict_bearing(logic signed [29:0] la,
            logic signed [30:0] oa, logic signed [29:0] lb, logic signed [30:0] ob);
        longint sa, ca, sb, cb, sd, cd, x, y, deg;
        rotate_sc(longint'(la) * 4, sa, ca);
        rotate_sc(longint'(lb) * 4, sb, cb);
        rotate_sc(longint'(ob) * 4 - longint'(oa) * 4, sd, cd);
        y = shr_floor(sd * cb, 30);
        x = shr_floor(ca * sb, 30) - shr_floor(shr_floor(sa * cb, 30) * cd, 30);
        if (x == 0 && y == 0)
            return '0;
        deg = shr_floor(vector_angle(y, x) * DEG_SCALE + (longint'(1) << 37), 38);
        if (deg < 0)
            deg += FULL_TURN;
        if (deg >= FULL_TURN)
            deg -= FULL_TURN;
        if (deg < 0)
            deg = 0;
        return deg[24:0];
    endfunction

    function automatic pair_row_t mk(longint la, longint oa, longint lb, longint ob,
            bit known, longint want);
        pair_row_t r;
        r.la = 30'(la); r.oa = 31'(oa); r.lb = 30'(lb); r.ob = 31'(ob);
        r.known = known; r.want = 25'(want);
        return r;
    endfunction

    // transfer one pair; start holds across back-to-back items
    task automatic send_pair(pair_row_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        lat_a <= r.la; lon_a <= r.oa; lat_b <= r.lb; lon_b <= r.ob;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        bearing_q.push_back(r.known ? r.want : predict_bearing(r.la, r.oa, r.lb, r.ob));
        n_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (bearing_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic pair_row_t random_pair();
        pair_row_t r;
        int mode;
        mode = $urandom_range(9);
        r.known = 0;
        r.want = '0;
        if (mode == 0)
        begin
            // full field widths, not limited to the LAT_MAX and LON_MAX range
            r.la = 30'($urandom); r.oa = 31'($urandom);
            r.lb = 30'($urandom); r.ob = 31'($urandom);
        end
        else
        begin
            r.la = 30'(longint'($urandom_range(32'(2 * LAT_MAX))) - LAT_MAX);
            r.lb = 30'(longint'($urandom_range(32'(2 * LAT_MAX))) - LAT_MAX);
            r.oa = 31'(longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX);
            r.ob = 31'(longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX);
            if (mode == 1)
                r.ob = r.oa;
            if (mode == 2)
            begin
                r.lb = r.la;
                r.ob = 31'(longint'(r.oa) + longint'($urandom_range(8)) - 4);
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n && done)
        begin
            if (bearing_q.size() == 0)
            begin
                $display("%0t: unexpected bearing %0d", $time, bearing);
                errors++;
            end
            else
            begin
                if (bearing !== bearing_q[0])
                begin
                    $display("%0t: bearing expected %0d actual %0d",
                             $time, bearing_q[0], bearing);
                    errors++;
                end
                void'(bearing_q.pop_front());
                n_checked++;
            end
        end
    end

    initial
    begin
        errors = 0; n_sent = 0; n_checked = 0; cycles = 0; idle_pct = 0;
        clk = 1'b0;
        rst_n = 1'b0; start = 1'b0;
        lat_a = '0; lon_a = '0; lat_b = '0; lon_b = '0;
        dir_rows[0]  = mk(0, 0, 0, 0, 1, 0);
        dir_rows[1]  = mk(0, 0, LAT_MAX, 0, 0, 0);
        dir_rows[2]  = mk(0, 0, -LAT_MAX, 0, 0, 0);
        dir_rows[3]  = mk(0, 0, 0, 1000000, 0, 0);
        dir_rows[4]  = mk(0, 0, 0, -1000000, 0, 0);
        dir_rows[5]  = mk(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 0, 0);
        dir_rows[6]  = mk(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0, 0);
        dir_rows[7]  = mk(100000000, 5, 100000000, 5, 1, 0);
        dir_rows[8]  = mk(0, -LON_MAX, 0, LON_MAX, 0, 0);
        dir_rows[9]  = mk(-536870912, -1073741824, -536870912, 1073741823, 0, 0);
        dir_rows[10] = mk(536870911, 1073741823, 536870911, -1073741824, 0, 0);
        dir_rows[11] = mk(200000000, 0, -100000000, 0, 0, 0);
        dir_rows[12] = mk(0, 0, -1, 0, 0, 0);
        dir_rows[13] = mk(0, 0, 0, 1, 0, 0);
        dir_rows[14] = mk(0, 0, 0, -1, 0, 0);
        dir_rows[15] = mk(300000000, 0, 300000000, LON_MAX, 0, 0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_pair(dir_rows[i]);
        // hold off until the pipeline is empty
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 54 : (ph == 3) ? 36 : 0;
            for (int k = 0; k < 150; k++)
                send_pair(random_pair());
        end
        drain();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d point pairs (directed extremes and random), %0d bearings checked",
                 n_sent, n_checked);
        if (errors == 0 && bearing_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
